[hw/rtl/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA pixel-data decoder: register
// indexes, pixel layout and the bit masks of the 5-5-5 format.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // configuration register indexes
  localparam logic [1:0] RegBytesPerPixel = 2'd0;
  localparam logic [1:0] RegRleMode       = 2'd1;
  localparam logic [1:0] RegPixelTotal    = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 25;
  localparam int unsigned TotalW   = 25;
  localparam int unsigned BppW     = 3;
  localparam int unsigned RepeatW  = 8;

  // reset values of the registers
  localparam logic [BppW-1:0]   BppReset   = 3'd4;
  localparam logic [TotalW-1:0] TotalReset = 25'd1;

  // group sizes as (bytes - 1)
  localparam logic [1:0] SizeM1Two   = 2'd1;
  localparam logic [1:0] SizeM1Three = 2'd2;
  localparam logic [1:0] SizeM1Four  = 2'd3;

  // 5-5-5 field masks and fixed alpha
  localparam logic [7:0] MaskRed     = 8'h7c;
  localparam logic [7:0] MaskGreenHi = 8'h03;
  localparam logic [7:0] MaskGreenLo = 8'he0;
  localparam logic [7:0] MaskBlue    = 8'h1f;
  localparam logic [7:0] MaskTopBit  = 8'h80;
  localparam logic [7:0] MaskCount   = 8'h7f;
  localparam logic [7:0] AlphaOpaque = 8'd255;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic               last;
    logic [RepeatW-1:0] repeat_res;
    pixel_t             pixel;
  } result_t;

endpackage

[hw/rtl/tgarle_unpack.sv]
// ----------------------------------------------------------------------------
// tgarle_unpack
// Turns a completed byte group (held bytes plus the closing byte) into one
// RGBA pixel for 2-, 3- and 4-byte pixel formats.
// ----------------------------------------------------------------------------
module tgarle_unpack (
  input  logic [7:0]         held0_i,
  input  logic [7:0]         held1_i,
  input  logic [7:0]         held2_i,
  input  logic [7:0]         last_byte_i,
  input  logic [1:0]         size_m1_i,
  output tgarle_pkg::pixel_t pixel_o
);
  import tgarle_pkg::*;

  logic [7:0] lo_q16;
  logic [7:0] hi_q16;

  assign lo_q16 = held0_i;
  assign hi_q16 = last_byte_i;

  // byte order is blue, green, red, alpha
  always_comb begin
    case (size_m1_i)
      SizeM1Four: begin
        pixel_o.blue  = held0_i;
        pixel_o.green = held1_i;
        pixel_o.red   = held2_i;
        pixel_o.alpha = last_byte_i;
      end
      SizeM1Three: begin
        pixel_o.blue  = held0_i;
        pixel_o.green = held1_i;
        pixel_o.red   = last_byte_i;
        pixel_o.alpha = AlphaOpaque;
      end
      default: begin
        // 5-5-5 little endian with alpha in the top bit
        pixel_o.red   = {hi_q16[6:0] & MaskRed[6:0], 1'b0};
        pixel_o.green = ((hi_q16 & MaskGreenHi) << 6) | ((lo_q16 & MaskGreenLo) >> 2);
        pixel_o.blue  = (lo_q16 & MaskBlue) << 3;
        pixel_o.alpha = hi_q16 & MaskTopBit;
      end
    endcase
  end

endmodule

[hw/rtl/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes the TGA truecolor pixel-data byte stream, raw or run-length
// encoded, into RGBA pixels with a repeat count and an end-of-image flag.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tdata[7:0] data_byte
//  m_axis   | out       | tdata red, green, blue, alpha, repeat_res; tlast last_of_image
//  cfg      | in        | cfg_idx_i: 0 bytes_per_pixel, 1 rle_mode, 2 pixel_total
//
//  one byte per cycle while the skid stage is empty; the rate is set by the per-byte state update
//  a finished pixel is registered into the output register, or into the skid stage
//  a two-entry output buffer (output and skid) takes one more pixel while the output stalls
//  reset and a pixel_total write restart the decoder; no clearing pass
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [tgarle_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgarle_pkg::CfgDataW-1:0] cfg_data_i,
  // byte input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  // pixel output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,   // red, green, blue, alpha, repeat_res
  output logic                           m_axis_tlast    // last_of_image
);
  import tgarle_pkg::*;

  // configuration
  logic [BppW-1:0]   bpp_q;
  logic              rle_q;

  // decoder state
  logic [7:0]        held_q [3];
  logic [7:0]        held_d [3];
  logic [1:0]        pos_q, pos_d;
  logic              await_hdr_q, await_hdr_d;
  logic              is_run_q, is_run_d;
  logic [7:0]        remain_q, remain_d;
  logic [TotalW-1:0] left_q, left_d;
  logic              done_q, done_d;

  // output buffer
  result_t out_q, skid_q, res;
  logic    out_vld_q, skid_vld_q;
  logic    res_vld;

  logic       in_fire, out_fire;
  logic [7:0] byte_in;
  logic [1:0] size_m1;
  logic [7:0] rep_raw, rep_clip, remain_step;
  pixel_t     pix;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign byte_in  = s_axis_tdata;

  // clamp pixel size to 2..4 bytes
  always_comb begin
    if (bpp_q < 3'd2)      size_m1 = SizeM1Two;
    else if (bpp_q > 3'd4) size_m1 = SizeM1Four;
    else                   size_m1 = 2'(bpp_q - 3'd1);
  end

  tgarle_unpack u_unpack (
    .held0_i     (held_q[0]),
    .held1_i     (held_q[1]),
    .held2_i     (held_q[2]),
    .last_byte_i (byte_in),
    .size_m1_i   (size_m1),
    .pixel_o     (pix)
  );

  // per-byte state update
  always_comb begin
    held_d      = held_q;
    pos_d       = pos_q;
    await_hdr_d = await_hdr_q;
    is_run_d    = is_run_q;
    remain_d    = remain_q;
    left_d      = left_q;
    done_d      = done_q;
    res_vld     = 1'b0;
    rep_raw     = 8'd1;
    rep_clip    = 8'd1;
    remain_step = remain_q;

    if (in_fire && !done_q) begin
      if (rle_q && await_hdr_q) begin
        // packet header
        is_run_d    = byte_in[7];
        remain_d    = (byte_in & MaskCount) + 8'd1;
        await_hdr_d = 1'b0;
        pos_d       = 2'd0;
      end else if (pos_q < size_m1) begin
        held_d[pos_q] = byte_in;
        pos_d         = pos_q + 2'd1;
      end else begin
        pos_d   = 2'd0;
        res_vld = 1'b1;
        if (rle_q) begin
          if (is_run_q) begin
            rep_raw     = remain_q;
            remain_step = 8'd0;
          end else if (remain_q != 8'd0) begin
            remain_step = remain_q - 8'd1;
          end
          remain_d = remain_step;
          if (remain_step == 8'd0) await_hdr_d = 1'b1;
        end
        // clip to what is left of the image
        if ({{(TotalW-RepeatW){1'b0}}, rep_raw} > left_q) rep_clip = left_q[7:0];
        else                                              rep_clip = rep_raw;
        if (rep_clip == 8'd0) rep_clip = 8'd1;
        left_d = left_q - {{(TotalW-RepeatW){1'b0}}, rep_clip};
        done_d = (left_d == '0);
      end
    end

    res.pixel      = pix;
    res.repeat_res = rep_clip;
    res.last       = done_d;
  end

  // configuration and decoder registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= BppReset;
      rle_q       <= 1'b0;
      held_q[0]   <= '0;
      held_q[1]   <= '0;
      held_q[2]   <= '0;
      pos_q       <= '0;
      await_hdr_q <= 1'b1;
      is_run_q    <= 1'b0;
      remain_q    <= '0;
      left_q      <= TotalReset;
      done_q      <= 1'b0;
    end else if (cfg_we_i && cfg_idx_i == RegPixelTotal) begin
      held_q[0]   <= '0;
      held_q[1]   <= '0;
      held_q[2]   <= '0;
      pos_q       <= '0;
      await_hdr_q <= 1'b1;
      is_run_q    <= 1'b0;
      remain_q    <= '0;
      left_q      <= cfg_data_i;
      done_q      <= (cfg_data_i == '0);
    end else begin
      if (cfg_we_i && cfg_idx_i == RegBytesPerPixel) bpp_q <= cfg_data_i[BppW-1:0];
      if (cfg_we_i && cfg_idx_i == RegRleMode)       rle_q <= cfg_data_i[0];
      held_q      <= held_d;
      pos_q       <= pos_d;
      await_hdr_q <= await_hdr_d;
      is_run_q    <= is_run_d;
      remain_q    <= remain_d;
      left_q      <= left_d;
      done_q      <= done_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_fire) begin
      out_vld_q <= res_vld;
    end else if (res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (!out_vld_q || out_fire) begin
      if (res_vld) out_q <= res;
    end else if (res_vld) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready = ~skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.repeat_res, out_q.pixel};
  assign m_axis_tlast  = out_q.last;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid holds an item while output is empty");

  a_done_matches_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q == (left_q == '0)) else $error("finished flag out of step with pixel count");

  a_packet_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !await_hdr_q |-> remain_q != 8'd0) else $error("open packet with no pixels left");

  a_repeat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.repeat_res != 8'd0) else $error("zero repeat count on output");

  a_no_result_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !res_vld) else $error("pixel produced after image end");

endmodule
